// File: rtl/sha256_hash_unit_macros.svh
// assertion macros for the sha256 hash unit
`ifndef SHA256_HASH_UNIT_MACROS_SVH
`define SHA256_HASH_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sha_pkg.sv
// shared types, constants and functions for the sha256 hash unit
`timescale 1ns / 1ps
package sha_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // word source selected by the controller for the schedule window
    typedef enum logic [1:0] {
        SRC_INPUT  = 2'd0,
        SRC_ZERO   = 2'd1,
        SRC_LEN_HI = 2'd2,
        SRC_LEN_LO = 2'd3
    } word_src_t;

    // controller to datapath commands
    typedef struct packed {
        logic      push;
        word_src_t src;
        logic      pad_final;
        logic      count_add;
        logic      start;
        logic      round;
        logic      finish;
        logic      reinit;
        logic      out_load;
        logic      out_shift;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] fill;
        logic       last_round;
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        rotr = (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// File: rtl/sha_datapath.sv
// sha256 datapath: length counter, schedule window, round logic, hash state, output shifter
`timescale 1ns / 1ps
module sha_datapath #(
    parameter int LENGTH_BITS = sha_pkg::LENGTH_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sha_pkg::dp_cmd_t cmd,
    output sha_pkg::dp_stat_t stat,
    input  logic [31:0]      in_word,
    input  logic [2:0]       in_bytes,
    input  logic             in_final,
    output logic [31:0]      out_word
);
    import sha_pkg::*;

    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [3:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [31:0] o_reg [8];
    logic [63:0] len64;
    logic [2:0]  nbytes;
    logic [31:0] push_word, pad_word, keep, w_new, w_cur, t1, t2;

    always_comb begin
        nbytes = (!in_final || in_bytes > 3'd4) ? 3'd4 : in_bytes;
        count_next = count_reg + LENGTH_BITS'({nbytes, 3'b000});
        len64 = 64'(count_reg);
        keep = (nbytes == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nbytes, 3'b000}));
        // four-byte final word pushes as is; its pad word comes on the next push
        if (in_final && nbytes != 3'd4)
            pad_word = (in_word & keep) | (32'h80000000 >> {nbytes, 3'b000});
        else
            pad_word = in_word;
        case (cmd.src)
            SRC_INPUT:  push_word = cmd.pad_final ? 32'h80000000 : pad_word;
            SRC_ZERO:   push_word = 32'h0;
            SRC_LEN_HI: push_word = len64[63:32];
            SRC_LEN_LO: push_word = len64[31:0];
            default:    push_word = 32'h0;
        endcase
        w_new = small_s1(w_reg[14]) + w_reg[9] + small_s0(w_reg[1]) + w_reg[0];
        w_cur = (round_reg < 6'd16) ? w_reg[0] : w_new;
        t1 = v_reg[7] + big_s1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + ROUND_K[round_reg] + w_cur;
        t2 = big_s0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
            ^ (v_reg[1] & v_reg[2]));
    end

    assign stat.fill       = fill_reg;
    assign stat.last_round = (round_reg == 6'd63);
    assign out_word        = o_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            fill_reg  <= 4'd0;
            round_reg <= 6'd0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
        end else begin
            if (cmd.reinit)
                count_reg <= '0;
            else if (cmd.count_add)
                count_reg <= count_next;
            // window shifts on push and on each round so index 0 is always the oldest word
            if (cmd.push) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= push_word;
                fill_reg  <= fill_reg + 4'd1;
            end else if (cmd.round) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_cur;
            end
            if (cmd.start) begin
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                round_reg <= 6'd0;
            end else if (cmd.round) begin
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.reinit) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
            end else if (cmd.finish) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            // the closing block's sum goes straight to the output shifter
            if (cmd.out_load) begin
                for (int i = 0; i < 8; i++) o_reg[i] <= h_reg[i] + v_reg[i];
            end else if (cmd.out_shift) begin
                for (int i = 0; i < 7; i++) o_reg[i] <= o_reg[i+1];
            end
        end
    end
endmodule

// File: rtl/sha_ctrl.sv
// sha256 controller: input handshake, padding sequence, round sequencing, digest output
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_final,
    input  logic [2:0]        in_bytes,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2:0]        out_index,
    output sha_pkg::dp_cmd_t  cmd,
    input  sha_pkg::dp_stat_t stat
);
    import sha_pkg::*;
    `include "sha256_hash_unit_macros.svh"

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD80  = 7'b0000010,
        ST_ZERO   = 7'b0000100,
        ST_LENLO  = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;   // where to go once the running block is compressed
    logic [2:0] idx_reg, idx_next;
    logic   acc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign out_index = idx_reg;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.src    = SRC_INPUT;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.count_add = 1'b1;
                    cmd.push      = 1'b1;
                    if (!in_final)
                        ret_next = ST_IDLE;
                    else if (in_bytes inside {[3'd4:3'd7]})
                        ret_next = ST_PAD80;
                    else
                        ret_next = ST_ZERO;
                    if (stat.fill == 4'd15) begin
                        cmd.start  = 1'b1;
                        state_next = ST_ROUND;
                    end else begin
                        state_next = ret_next;
                    end
                end
            end
            ST_PAD80: begin
                cmd.push      = 1'b1;
                cmd.pad_final = 1'b1;
                ret_next      = ST_ZERO;
                if (stat.fill == 4'd15) begin
                    cmd.start = 1'b1; state_next = ST_ROUND;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                cmd.push = 1'b1;
                if (stat.fill == 4'd14) begin
                    cmd.src    = SRC_LEN_HI;
                    state_next = ST_LENLO;
                end else begin
                    cmd.src  = SRC_ZERO;
                    ret_next = ST_ZERO;
                    if (stat.fill == 4'd15) begin
                        cmd.start = 1'b1; state_next = ST_ROUND;
                    end
                end
            end
            ST_LENLO: begin
                cmd.push = 1'b1; cmd.src = SRC_LEN_LO; cmd.start = 1'b1;
                ret_next   = ST_OUT;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (stat.last_round) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                // closing block: load the digest and restore the initial state
                if (ret_reg == ST_OUT) begin
                    cmd.out_load = 1'b1;
                    cmd.reinit   = 1'b1;
                end
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (m_tready) begin
                    cmd.out_shift = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

    `SHA_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_tready, !m_tvalid,
        "input taken while digest pending")
    `SHA_ASSERT_NEXT(a_out_idx_wrap, aclk, aresetn,
        m_tvalid && m_tready && idx_reg == 3'd7, state_reg == ST_IDLE,
        "digest did not end after eighth word")
    `SHA_ASSERT_IMPL(a_out_idx_zero, aclk, aresetn, $rose(m_tvalid), idx_reg == 3'd0,
        "digest did not start at word zero")
    `SHA_ASSERT_IMPL(a_state_onehot, aclk, aresetn, 1'b1, $onehot(state_reg),
        "controller state not one-hot")
endmodule

// File: rtl/sha256_hash_unit.sv
// sha256 hash unit top level
//  channel | dir | tdata                                   | tuser                | tlast
//  s_      | in  | [31:0] message_word                     | [2:0] bytes_valid    | final_word
//  m_      | out | [31:0] digest_word                      | [2:0] digest_index   | digest_last
// one input word per cycle while a block fills; the sixteenth word of a block then holds
// the input through the 64 rounds of the single round unit and the hash update
// a final word adds padding words and the message length, and possibly a second block
// the digest then leaves as eight words at the rate m_tready allows; input waits meanwhile
// synchronous active-low reset restores the initial hash values
`timescale 1ns / 1ps
module sha256_hash_unit #(
    parameter int LENGTH_BITS = sha_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] message_word
    input  logic [2:0]  s_tuser,  // [2:0] bytes_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] digest_word
    output logic [2:0]  m_tuser,  // [2:0] digest_index
    output logic        m_tlast
);
    import sha_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_final(s_tlast), .in_bytes(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_index(m_tuser), .cmd(cmd), .stat(stat)
    );

    sha_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_word(s_tdata), .in_bytes(s_tuser), .in_final(s_tlast),
        .out_word(m_tdata)
    );

    assign m_tlast = (m_tuser == 3'd7);
endmodule
